/* design/dbc_pkg.sv */
// shared types, permutation tables and round functions of the des block cipher
package dbc_pkg;

   localparam int unsigned NUM_ROUNDS = 16;

   // transaction command codes
   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   typedef logic [47:0] subkey_type;
   typedef logic [NUM_ROUNDS-1:0][47:0] subkey_arr_type;

   // payload carried from one round stage to the next
   typedef struct packed {
      logic        cmd;
      logic [31:0] left;
      logic [31:0] right;
   } stage_type;

   localparam logic [6:0] IP_TAB [0:63] = '{
      7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
      7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
      7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
      7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
      7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
      7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
      7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7};

   localparam logic [6:0] IPINV_TAB [0:63] = '{
      7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
      7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
      7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
      7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
      7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
      7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
      7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
      7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25};

   localparam logic [6:0] PC1_TAB [0:55] = '{
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
      7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
      7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
      7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
      7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
      7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
      7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
      7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4};

   localparam logic [5:0] PC2_TAB [0:47] = '{
      6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
      6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
      6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
      6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
      6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
      6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
      6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
      6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32};

   // total left rotation of the key halves after each round
   localparam logic [4:0] ROT_CUM_TAB [0:NUM_ROUNDS-1] = '{
      5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
      5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28};

   localparam logic [5:0] E_TAB [0:47] = '{
      6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
      6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
      6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
      6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
      6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
      6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
      6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
      6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1};

   localparam logic [5:0] P_TAB [0:31] = '{
      6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
      6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
      6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
      6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25};

   localparam logic [3:0] SBOX_TAB [0:7][0:3][0:15] = '{
      '{'{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7},
        '{4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8},
        '{4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0},
        '{4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13}},
      '{'{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10},
        '{4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5},
        '{4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15},
        '{4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9}},
      '{'{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8},
        '{4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1},
        '{4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7},
        '{4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12}},
      '{'{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15},
        '{4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9},
        '{4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4},
        '{4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14}},
      '{'{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9},
        '{4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6},
        '{4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14},
        '{4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3}},
      '{'{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11},
        '{4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8},
        '{4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6},
        '{4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13}},
      '{'{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1},
        '{4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6},
        '{4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2},
        '{4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12}},
      '{'{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7},
        '{4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2},
        '{4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8},
        '{4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}}};

   // table entries count bits from 1 at the msb
   function automatic logic [63:0] ip_perm(input logic [63:0] din);
      logic [63:0] dout;
      logic [5:0]  idx;
      for (int i = 0; i < 64; i++) begin
         idx = 6'(7'd64 - IP_TAB[i]);
         dout[63-i] = din[idx];
      end
      return dout;
   endfunction

   function automatic logic [63:0] ipinv_perm(input logic [63:0] din);
      logic [63:0] dout;
      logic [5:0]  idx;
      for (int i = 0; i < 64; i++) begin
         idx = 6'(7'd64 - IPINV_TAB[i]);
         dout[63-i] = din[idx];
      end
      return dout;
   endfunction

   function automatic logic [55:0] pc1_perm(input logic [63:0] din);
      logic [55:0] dout;
      logic [5:0]  idx;
      for (int i = 0; i < 56; i++) begin
         idx = 6'(7'd64 - PC1_TAB[i]);
         dout[55-i] = din[idx];
      end
      return dout;
   endfunction

   function automatic logic [47:0] pc2_perm(input logic [55:0] din);
      logic [47:0] dout;
      logic [5:0]  idx;
      for (int i = 0; i < 48; i++) begin
         idx = 6'd56 - PC2_TAB[i];
         dout[47-i] = din[idx];
      end
      return dout;
   endfunction

   function automatic logic [27:0] rotl28(input logic [27:0] v, input logic [4:0] sh);
      logic [55:0] dbl;
      dbl = {v, v} << sh;
      return dbl[55:28];
   endfunction

   function automatic logic [47:0] e_expand(input logic [31:0] din);
      logic [47:0] dout;
      logic [4:0]  idx;
      for (int i = 0; i < 48; i++) begin
         idx = 5'(6'd32 - E_TAB[i]);
         dout[47-i] = din[idx];
      end
      return dout;
   endfunction

   function automatic logic [31:0] p_perm(input logic [31:0] din);
      logic [31:0] dout;
      logic [4:0]  idx;
      for (int i = 0; i < 32; i++) begin
         idx = 5'(6'd32 - P_TAB[i]);
         dout[31-i] = din[idx];
      end
      return dout;
   endfunction

   function automatic logic [31:0] sbox_sub(input logic [47:0] din);
      logic [31:0] dout;
      logic [5:0]  b;
      for (int i = 0; i < 8; i++) begin
         b = din[47-6*i -: 6];
         dout[31-4*i -: 4] = SBOX_TAB[i][{b[5], b[0]}][b[4:1]];
      end
      return dout;
   endfunction

   function automatic logic [31:0] feistel(input logic [31:0] r, input subkey_type k);
      return p_perm(sbox_sub(e_expand(r) ^ k));
   endfunction

endpackage

/* design/des_block_cipher_top.sv */
// top level of the pipelined des block cipher
// A transaction is taken at every rising edge where start is high (busy is
// always low, one block per cycle is sustained). The block goes through an
// input register holding the initially permuted halves, sixteen register
// stages of one feistel round each, and an output register that swaps the
// halves and applies the inverse permutation. rsp_strobe is registered with
// the result and travels with the block through all of these registers;
// results leave in the order their transactions came in. The receiver
// cannot stall the result port; there is no backpressure anywhere
// in the pipe. The key
// register is written through csr_write_en / csr_write_data and must only
// change while no transaction is in flight; all sixteen subkeys are wired
// from it and decryption simply selects them in reverse order per stage.
module des_block_cipher_top
   import dbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input transaction
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [63:0] req_data_block,
   // result transaction
   output logic        rsp_strobe,
   output logic [63:0] rsp_result_block,
   // key register
   input  logic        csr_write_en,
   input  logic [63:0] csr_write_data
);

   logic [63:0]    cipher_key_ff;
   subkey_arr_type subkeys;

   // stage 0 is the input register, stage NUM_ROUNDS the last round output
   logic           stage_valid [0:NUM_ROUNDS];
   stage_type      stage_data  [0:NUM_ROUNDS];

   logic           in_valid_ff;
   stage_type      in_stage_ff;
   stage_type      in_stage_in;
   logic           req_accept;

   logic           rsp_strobe_ff;
   logic [63:0]    rsp_result_block_ff;
   logic [63:0]    rsp_result_block_in;

   // the pipe never backs up, so a transaction is always taken
   assign busy       = 1'b0;
   assign req_accept = start & ~busy;

   // key register
   always_ff @(posedge clock) begin
      if (reset) begin
         cipher_key_ff <= '0;
      end else if (csr_write_en) begin
         cipher_key_ff <= csr_write_data;
      end
   end

   dbc_key_sched u_key_sched (
      .cipher_key (cipher_key_ff),
      .subkeys    (subkeys)
   );

   // input register: initial permutation is routing only
   always_comb begin
      in_stage_in.cmd                       = req_cmd;
      {in_stage_in.left, in_stage_in.right} = ip_perm(req_data_block);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      in_stage_ff <= in_stage_in;
   end

   assign stage_valid[0] = in_valid_ff;
   assign stage_data[0]  = in_stage_ff;

   // sixteen round stages; decryption takes the subkeys in reverse order
   for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
      dbc_round u_round (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[g]),
         .in_stage  (stage_data[g]),
         .enc_key   (subkeys[g]),
         .dec_key   (subkeys[NUM_ROUNDS-1-g]),
         .out_valid (stage_valid[g+1]),
         .out_stage (stage_data[g+1])
      );
   end

   // output register: swap halves, inverse permutation
   assign rsp_result_block_in = ipinv_perm({stage_data[NUM_ROUNDS].right,
                                            stage_data[NUM_ROUNDS].left});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= stage_valid[NUM_ROUNDS];
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_block_ff <= rsp_result_block_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_result_block = rsp_result_block_ff;

   // every accepted transaction comes out on the result port
   a_accept_to_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##18 rsp_strobe)
      else $error("accepted transaction produced no result after 18 cycles");

   // no result without a matching accepted transaction
   a_result_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_accept, 18))
      else $error("result strobe without matching transaction");

   // the output strobe follows the last round stage in the next cycle
   a_strobe_follows_last_round: assert property (@(posedge clock) disable iff (reset)
      stage_valid[NUM_ROUNDS] |=> rsp_strobe)
      else $error("last round output not presented on the result port");

endmodule

/* design/dbc_key_sched.sv */
// round subkey derivation from the key register (pc-1, rotations, pc-2)
module dbc_key_sched
   import dbc_pkg::*;
(
   input  logic [63:0]    cipher_key,
   output subkey_arr_type subkeys
);

   logic [55:0] cd;

   assign cd = pc1_perm(cipher_key);

   // each round uses a fixed total rotation, so every subkey is pure routing
   for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_sub
      assign subkeys[g] = pc2_perm({rotl28(cd[55:28], ROT_CUM_TAB[g]),
                                    rotl28(cd[27:0],  ROT_CUM_TAB[g])});
   end

endmodule

/* design/dbc_round.sv */
// one registered feistel round stage
module dbc_round
   import dbc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  stage_type  in_stage,
   input  subkey_type enc_key,
   input  subkey_type dec_key,
   output logic       out_valid,
   output stage_type  out_stage
);

   logic       valid_ff;
   stage_type  stage_ff;
   stage_type  stage_in;
   subkey_type round_key;

   always_comb begin
      round_key      = (in_stage.cmd == CMD_DECRYPT) ? dec_key : enc_key;
      stage_in.cmd   = in_stage.cmd;
      stage_in.left  = in_stage.right;
      stage_in.right = in_stage.left ^ feistel(in_stage.right, round_key);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule
